FILE: rtl/core/mp4_box_framing_check_defines.svh
// ----------------------------------------------------------------------------
// mp4 box framing check: assertion macros
// Shared concurrent assertion wrappers; empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef MP4_BOX_FRAMING_CHECK_DEFINES_SVH
`define MP4_BOX_FRAMING_CHECK_DEFINES_SVH

`ifndef SYNTHESIS

`define MBFC_ASSERT_ALWAYS(lbl, clk, rst_n, expr) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
		else $error("mbfc: invariant violated");

`define MBFC_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("mbfc: implication violated");

`define MBFC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("mbfc: next-cycle implication violated");

`else

`define MBFC_ASSERT_ALWAYS(lbl, clk, rst_n, expr)

`define MBFC_ASSERT_SAME(lbl, clk, rst_n, ante, cons)

`define MBFC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

FILE: rtl/core/mbfc_pkg.sv
// ----------------------------------------------------------------------------
// mp4 box framing check: package
// Shared types, codes and helpers for the top-level box walk.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package mbfc_pkg;

	localparam int unsigned MBFC_MAX_BOXES = 262144;

	localparam logic [31:0] FOURCC_MOOV = 32'h6D6F6F76;

	localparam logic [3:0] HDR_SHORT_LAST = 4'd7;
	localparam logic [3:0] HDR_LONG_FIRST = 4'd8;
	localparam logic [3:0] HDR_LONG_LAST  = 4'd15;
	localparam logic [3:0] HDR_TYPE_FIRST = 4'd4;

	localparam logic OP_BYTE = 1'b0;
	localparam logic OP_EOF  = 1'b1;

	typedef enum logic [2:0] {
		PH_HEADER  = 3'b001,
		PH_PAYLOAD = 3'b010,
		PH_TO_END  = 3'b100
	} phase_t;

	typedef struct packed {
		logic       vld;
		logic       op;
		logic [7:0] data;
	} item_t;

	typedef struct packed {
		logic vld;
		logic verdict;
	} result_t;

	function automatic logic type_printable(input logic [31:0] t);
		logic ok;
		ok = 1'b1;
		for (int k = 0; k < 4; k++) begin
			if (t[8*k +: 8] < 8'h20 || t[8*k +: 8] > 8'h7E) begin
				ok = 1'b0;
			end
		end
		return ok;
	endfunction

endpackage

`default_nettype wire

FILE: rtl/core/mbfc_in_stage.sv
// ----------------------------------------------------------------------------
// mp4 box framing check: input stage
// Input register; releases an end-of-file item only when the result slot
// can take it, byte items always move on.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mbfc_in_stage
	import mbfc_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_stall,
	input  wire logic       operation,
	input  wire logic [7:0] data_byte,
	input  wire logic       res_full,
	input  wire logic       res_stall,
	output item_t           item
);

	logic       vld_s1;
	logic       op_s1;
	logic [7:0] data_s1;
	logic       fire;
	logic       take;

	assign fire     = vld_s1 && (op_s1 == OP_BYTE || !res_full || !res_stall);
	assign in_stall = vld_s1 && !fire;
	assign take     = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (take) begin
			vld_s1 <= 1'b1;
		end else if (fire) begin
			vld_s1 <= 1'b0;
		end
	end

	// hold payload unless a new transfer lands
	always_ff @(posedge clk) begin
		if (take) begin
			op_s1   <= operation;
			data_s1 <= data_byte;
		end
	end

	assign item = '{vld: fire, op: op_s1, data: data_s1};

endmodule

`default_nettype wire

FILE: rtl/core/mbfc_walk.sv
// ----------------------------------------------------------------------------
// mp4 box framing check: box walker
// Per-byte header collection, payload skipping and verdict latching.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "mp4_box_framing_check_defines.svh"

module mbfc_walk
	import mbfc_pkg::*;
#(
	parameter int unsigned MAX_BOXES = MBFC_MAX_BOXES
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  item_t     item,
	output result_t   res
);

	localparam int unsigned CNT_W = $clog2(MAX_BOXES + 1);
	localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_BOXES);

	phase_t             phase_q,        phase_d;
	logic [3:0]         hdr_idx_q,      hdr_idx_d;
	logic [31:0]        short_size_q,   short_size_d;
	logic [31:0]        box_type_q,     box_type_d;
	logic [63:0]        long_size_q,    long_size_d;
	logic [63:0]        payload_left_q, payload_left_d;
	logic [CNT_W-1:0]   box_count_q,    box_count_d;
	logic               moov_seen_q,    moov_seen_d;
	logic               decided_q,      decided_d;
	logic               latched_q,      latched_d;

	logic               hdr_start;
	logic [31:0]        ss_base;
	logic [31:0]        ss_new;
	logic [31:0]        type_new;
	logic [63:0]        ls_new;
	logic [63:0]        ss_len;
	logic [63:0]        ls_len;
	logic [63:0]        pl_dec;

	assign hdr_start = (hdr_idx_q == 4'd0);
	assign ss_base   = hdr_start ? 32'd0 : short_size_q;
	assign ss_new    = {ss_base[23:0], item.data};
	assign type_new  = {box_type_q[23:0], item.data};
	assign ls_new    = {long_size_q[55:0], item.data};
	assign ss_len    = {32'd0, short_size_q} - 64'd8;
	assign ls_len    = ls_new - 64'd16;
	assign pl_dec    = payload_left_q - 64'd1;

	always_comb begin
		phase_d        = phase_q;
		hdr_idx_d      = hdr_idx_q;
		short_size_d   = short_size_q;
		box_type_d     = box_type_q;
		long_size_d    = long_size_q;
		payload_left_d = payload_left_q;
		box_count_d    = box_count_q;
		moov_seen_d    = moov_seen_q;
		decided_d      = decided_q;
		latched_d      = latched_q;
		res            = '0;

		if (item.vld) begin
			if (item.op == OP_EOF) begin
				res.vld = 1'b1;
				if (decided_q) begin
					res.verdict = latched_q;
				end else begin
					unique case (phase_q)
						PH_HEADER:  res.verdict = (hdr_idx_q != 4'd0) || !moov_seen_q;
						PH_PAYLOAD: res.verdict = 1'b1;
						PH_TO_END:  res.verdict = !moov_seen_q;
						default:    res.verdict = 1'b1;
					endcase
				end
				// return to reset state for the next file
				phase_d        = PH_HEADER;
				hdr_idx_d      = 4'd0;
				short_size_d   = 32'd0;
				box_type_d     = 32'd0;
				long_size_d    = 64'd0;
				payload_left_d = 64'd0;
				box_count_d    = '0;
				moov_seen_d    = 1'b0;
				decided_d      = 1'b0;
				latched_d      = 1'b0;
			end else if (!decided_q) begin
				unique case (phase_q)
					PH_HEADER: begin
						if (hdr_start && box_count_q >= CNT_MAX) begin
							decided_d = 1'b1;
							latched_d = 1'b0;
						end else begin
							if (hdr_start) begin
								box_count_d = box_count_q + CNT_W'(1);
								box_type_d  = 32'd0;
								long_size_d = 64'd0;
							end
							priority if (hdr_idx_q < HDR_TYPE_FIRST) begin
								short_size_d = ss_new;
							end else if (hdr_idx_q < HDR_LONG_FIRST) begin
								box_type_d = type_new;
							end else begin
								long_size_d = ls_new;
							end

							priority if (hdr_idx_q == HDR_SHORT_LAST) begin
								priority if (!type_printable(type_new)) begin
									decided_d = 1'b1;
									latched_d = (type_new == 32'd0);
								end else if (short_size_q == 32'd1) begin
									hdr_idx_d = HDR_LONG_FIRST;
								end else if (short_size_q == 32'd0) begin
									if (type_new == FOURCC_MOOV) begin
										moov_seen_d = 1'b1;
									end
									phase_d   = PH_TO_END;
									hdr_idx_d = 4'd0;
								end else if (short_size_q < 32'd8) begin
									decided_d = 1'b1;
									latched_d = 1'b0;
								end else begin
									if (type_new == FOURCC_MOOV) begin
										moov_seen_d = 1'b1;
									end
									payload_left_d = ss_len;
									phase_d   = (ss_len != 64'd0) ? PH_PAYLOAD : PH_HEADER;
									hdr_idx_d = 4'd0;
								end
							end else if (hdr_idx_q == HDR_LONG_LAST) begin
								if (ls_new < 64'd16) begin
									decided_d = 1'b1;
									latched_d = 1'b0;
								end else begin
									if (box_type_q == FOURCC_MOOV) begin
										moov_seen_d = 1'b1;
									end
									payload_left_d = ls_len;
									phase_d   = (ls_len != 64'd0) ? PH_PAYLOAD : PH_HEADER;
									hdr_idx_d = 4'd0;
								end
							end else begin
								hdr_idx_d = hdr_idx_q + 4'd1;
							end
						end
					end
					PH_PAYLOAD: begin
						payload_left_d = pl_dec;
						if (pl_dec == 64'd0) begin
							phase_d = PH_HEADER;
						end
					end
					PH_TO_END: begin
						// drop bytes of a box that runs to end of file
					end
					default: begin
						phase_d = PH_HEADER;
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q        <= PH_HEADER;
			hdr_idx_q      <= 4'd0;
			short_size_q   <= 32'd0;
			box_type_q     <= 32'd0;
			long_size_q    <= 64'd0;
			payload_left_q <= 64'd0;
			box_count_q    <= '0;
			moov_seen_q    <= 1'b0;
			decided_q      <= 1'b0;
			latched_q      <= 1'b0;
		end else begin
			phase_q        <= phase_d;
			hdr_idx_q      <= hdr_idx_d;
			short_size_q   <= short_size_d;
			box_type_q     <= box_type_d;
			long_size_q    <= long_size_d;
			payload_left_q <= payload_left_d;
			box_count_q    <= box_count_d;
			moov_seen_q    <= moov_seen_d;
			decided_q      <= decided_d;
			latched_q      <= latched_d;
		end
	end

	`MBFC_ASSERT_SAME(a_payload_nonzero, clk, arst_n, phase_q == PH_PAYLOAD, payload_left_q != 64'd0)
	`MBFC_ASSERT_SAME(a_idx_in_header, clk, arst_n, phase_q != PH_HEADER, hdr_idx_q == 4'd0)
	`MBFC_ASSERT_ALWAYS(a_count_bound, clk, arst_n, box_count_q <= CNT_MAX)
	`MBFC_ASSERT_NEXT(a_eof_clears, clk, arst_n, item.vld && item.op == OP_EOF, !decided_q && box_count_q == '0 && !moov_seen_q)

endmodule

`default_nettype wire

FILE: rtl/core/mbfc_out_reg.sv
// ----------------------------------------------------------------------------
// mp4 box framing check: result register
// Holds one verdict until the downstream side takes it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mbfc_out_reg
	import mbfc_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  result_t   res,
	output logic      out_valid,
	input  wire logic out_stall,
	output logic      verdict
);

	logic vld_q;
	logic verdict_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (res.vld) begin
			vld_q <= 1'b1;
		end else if (!out_stall) begin
			vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res.vld) begin
			verdict_q <= res.verdict;
		end
	end

	assign out_valid = vld_q;
	assign verdict   = verdict_q;

endmodule

`default_nettype wire

FILE: rtl/core/mp4_box_framing_check.sv
// ----------------------------------------------------------------------------
// mp4 box framing check
// Walks the top-level boxes of an mp4 byte stream and reports on end of file
// whether the file ends before its boxes do or holds no moov box.
// ----------------------------------------------------------------------------
// Throughput: one item per cycle, bytes and end-of-file items alike, except while in_stall holds an end-of-file item.
// Path: an end-of-file item passes through the input register, then the walk
//   logic into the result register, which drives out_valid.
// The end-of-file item waits in the input register only while an earlier
//   verdict still sits unclaimed in the result register.
// Reset: arst_n clears all walk state; no clearing pass, ready right away.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mp4_box_framing_check
	import mbfc_pkg::*;
#(
	parameter int unsigned MAX_BOXES = MBFC_MAX_BOXES
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_stall,
	input  wire logic       operation,
	input  wire logic [7:0] data_byte,
	output logic            out_valid,
	input  wire logic       out_stall,
	output logic            verdict
);

	item_t   item;
	result_t res;

	mbfc_in_stage u_in_stage (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.operation (operation),
		.data_byte (data_byte),
		.res_full  (out_valid),
		.res_stall (out_stall),
		.item      (item)
	);

	mbfc_walk #(
		.MAX_BOXES (MAX_BOXES)
	) u_walk (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item),
		.res    (res)
	);

	mbfc_out_reg u_out_reg (
		.clk       (clk),
		.arst_n    (arst_n),
		.res       (res),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.verdict   (verdict)
	);

endmodule

`default_nettype wire
